[rtl/rf_pulse_train_capture_defines.svh]
// Assertion macros of the pulse train capture checker.
`ifndef RF_PULSE_TRAIN_CAPTURE_DEFINES_SVH
`define RF_PULSE_TRAIN_CAPTURE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RFPTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RFPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rfptc_pkg.sv]
// Types, constants and codes of the pulse train capture block.
package rfptc_pkg;

  localparam int unsigned BUF_DEPTH = 64;
  localparam int unsigned BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned OFS_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [BUF_AW-1:0] BUF_LAST = BUF_AW'(BUF_DEPTH - 1);
  localparam logic [OFS_W-1:0]  OFS_END  = OFS_W'(BUF_DEPTH);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [14:0] PULSE_SAT = 15'h7FFF;
  localparam logic [15:0] WRAP_MAX  = 16'hFFFF;

  // First stored pulse level codes
  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_HIGH = 2'd1;
  localparam logic [1:0] LVL_NONE = 2'd2;

  // Register reset values
  localparam logic [30:0] START_MIN_RST   = 31'd5000;
  localparam logic [15:0] COUNT_MIN_RST   = 16'd25;
  localparam logic [15:0] COUNT_MAX_RST   = 16'd0;
  localparam logic [30:0] SILENCE_MIN_RST = 31'd20000;

  typedef enum logic [1:0] {
    CMD_EDGE    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_STOP    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MIN   = 2'd0,
    CFG_COUNT_MIN   = 2'd1,
    CFG_COUNT_MAX   = 2'd2,
    CFG_SILENCE_MIN = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_CALC,
    ST_EDGE_COMMIT,
    ST_RD_ISSUE,
    ST_RD_TAKE,
    ST_RESTART,
    ST_STOP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] timestamp;
    logic        edge_rising;
  } item_t;

  typedef struct packed {
    logic               capture_done;
    logic               start_seen;
    logic [31:0]        pulse_count;
    logic [31:0]        train_duration;
    logic [15:0]        overflow_total;
    logic [1:0]         first_level;
    logic signed [15:0] pulse_value;
    logic               pulse_valid;
  } result_t;

  // Step commands from controller to datapath
  typedef struct packed {
    logic load;
    logic edge_calc;
    logic edge_commit;
    logic rd_issue;
    logic rd_take;
    logic restart;
    logic stop;
  } ctl_t;

endpackage

[rtl/rf_pulse_train_capture.sv]
// Top level of the RF pulse train capture block.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------
//  command  | start_i in, busy_o out        | item_i   (cmd, timestamp, edge)
//  result   | result_valid_o strobe out     | result_o (status, counts, pulse)
//  config   | cfg_valid_i in, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Edge words go through load, calc, commit; reads through load, issue, take;
// restart and stop through load and their own step; each ends in the one-cycle
// result strobe. The edge path is set by the subtract, then compare-and-update
// step; the read path by the registered read of the ring buffer RAM.
// Reset is asynchronous: capture state and per-entry valid bits clear at once,
// the buffer RAM itself is never cleared. Results cannot be stalled.
module rf_pulse_train_capture (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command word
  input  logic                            start_i,
  output logic                            busy_o,
  input  rfptc_pkg::item_t                item_i,
  // result word
  output logic                            result_valid_o,
  output rfptc_pkg::result_t              result_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rfptc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rfptc_pkg::CFG_DW-1:0]    cfg_data_i
);

  import rfptc_pkg::*;

  ctl_t ctl;

  // The user must write registers only while idle; the block itself does not enforce it, so writes are always taken.
  assign cfg_ready_o = 1'b1;

  rfptc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (item_i.cmd),
    .ctl_o          (ctl),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  // Datapath holds the capture state; result_o shows it after each word.
  rfptc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule

[rtl/rfptc_ram.sv]
// Generic single write port, single read port RAM with registered read.
module rfptc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rfptc_ctrl.sv]
// Sequencing state machine of the pulse train capture block.
module rfptc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  rfptc_pkg::cmd_e cmd_i,
  output rfptc_pkg::ctl_t ctl_o,
  output logic            busy_o,
  output logic            result_valid_o
);

  import rfptc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctl_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctl_o.load = 1'b1;
          case (cmd_i)
            CMD_EDGE:    state_d = ST_EDGE_CALC;
            CMD_READ:    state_d = ST_RD_ISSUE;
            CMD_RESTART: state_d = ST_RESTART;
            CMD_STOP:    state_d = ST_STOP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE_CALC: begin
        ctl_o.edge_calc = 1'b1;
        state_d         = ST_EDGE_COMMIT;
      end
      ST_EDGE_COMMIT: begin
        ctl_o.edge_commit = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_RD_ISSUE: begin
        ctl_o.rd_issue = 1'b1;
        state_d        = ST_RD_TAKE;
      end
      ST_RD_TAKE: begin
        ctl_o.rd_take = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_RESTART: begin
        ctl_o.restart = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_STOP: begin
        ctl_o.stop = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/rfptc_dp.sv]
// Datapath: registers, timing compares, ring buffer and read pointer.
module rfptc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rfptc_pkg::ctl_t                     ctl_i,
  input  rfptc_pkg::item_t                    item_i,
  input  logic                                cfg_we_i,
  input  logic [rfptc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rfptc_pkg::CFG_DW-1:0]        cfg_data_i,
  output rfptc_pkg::result_t                  result_o
);

  import rfptc_pkg::*;

  // configuration
  logic [30:0] start_min_q, silence_min_q;
  logic [15:0] count_min_q, count_max_q;

  // latched item and edge stage
  item_t       item_q;
  logic [30:0] dur_q, dur_d;
  logic        win_ok_q, win_ok_d;

  // capture state
  logic [31:0]          prev_q, prev_d;
  logic                 ended_q, ended_d;
  logic                 armed_q, armed_d;
  logic [1:0]           lvl_q, lvl_d;
  logic [BUF_AW-1:0]    wi_q, wi_d;
  logic [15:0]          wraps_q, wraps_d;
  logic [31:0]          count_q, count_d;
  logic [31:0]          total_q, total_d;
  logic [BUF_DEPTH-1:0] filled_q, filled_d;
  logic [OFS_W-1:0]     ofs_q, ofs_d;
  logic                 rd_stop_q, rd_stop_d;
  logic                 rd_hit_q, rd_hit_d;
  logic signed [15:0]   val_q, val_d;
  logic                 valid_q, valid_d;

  // edge commit terms
  logic [31:0]          diff;
  logic                 arm_nx, dur_big, sil_hit, end_now, clr_now;
  logic [14:0]          dur_sat;
  logic [BUF_AW-1:0]    wi_base, wi_next;
  logic [15:0]          wraps_base;
  logic [31:0]          count_base, total_base;
  logic [1:0]           lvl_base;
  logic [BUF_DEPTH-1:0] filled_base;

  // read terms
  logic [BUF_AW-1:0]    rd_first, rd_pos;
  logic [BUF_AW:0]      rd_sum;
  logic                 rd_miss;

  // ring buffer
  logic              ram_we, ram_re;
  logic [15:0]       ram_wdata, ram_rdata;

  rfptc_ram #(
    .WIDTH (16),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_base),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_pos),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_min_q   <= START_MIN_RST;
      count_min_q   <= COUNT_MIN_RST;
      count_max_q   <= COUNT_MAX_RST;
      silence_min_q <= SILENCE_MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_MIN:   start_min_q   <= cfg_data_i[30:0];
        CFG_COUNT_MIN:   count_min_q   <= cfg_data_i[15:0];
        CFG_COUNT_MAX:   count_max_q   <= cfg_data_i[15:0];
        CFG_SILENCE_MIN: silence_min_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      item_q <= item_i;
    end
    dur_q    <= dur_d;
    win_ok_q <= win_ok_d;
    rd_hit_q <= rd_hit_d;
    val_q    <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      ended_q   <= 1'b0;
      armed_q   <= 1'b0;
      lvl_q     <= LVL_NONE;
      wi_q      <= '0;
      wraps_q   <= '0;
      count_q   <= '0;
      total_q   <= '0;
      filled_q  <= '0;
      ofs_q     <= '0;
      rd_stop_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      prev_q    <= prev_d;
      ended_q   <= ended_d;
      armed_q   <= armed_d;
      lvl_q     <= lvl_d;
      wi_q      <= wi_d;
      wraps_q   <= wraps_d;
      count_q   <= count_d;
      total_q   <= total_d;
      filled_q  <= filled_d;
      ofs_q     <= ofs_d;
      rd_stop_q <= rd_stop_d;
      valid_q   <= valid_d;
    end
  end

  // Edge terms. Silence is judged on the saturated length.
  assign diff    = item_q.timestamp - prev_q;
  assign arm_nx  = armed_q | (dur_q > start_min_q);
  assign dur_big = dur_q > {16'b0, PULSE_SAT};
  assign dur_sat = dur_big ? PULSE_SAT : dur_q[14:0];
  assign sil_hit = item_q.edge_rising &
                   (dur_big ? ({16'b0, PULSE_SAT} > silence_min_q) : (dur_q > silence_min_q));
  assign end_now = sil_hit & win_ok_q;
  assign clr_now = sil_hit & ~win_ok_q;

  assign wi_base     = clr_now ? '0 : wi_q;
  assign wraps_base  = clr_now ? '0 : wraps_q;
  assign count_base  = clr_now ? '0 : count_q;
  assign total_base  = clr_now ? '0 : total_q;
  assign lvl_base    = clr_now ? LVL_NONE : lvl_q;
  assign filled_base = clr_now ? '0 : filled_q;
  assign wi_next     = (wi_base == BUF_LAST) ? '0 : wi_base + 1'b1;
  assign ram_wdata   = item_q.edge_rising ? 16'(16'd0 - {1'b0, dur_sat}) : {1'b0, dur_sat};

  // Read position: oldest entry is just past the write index once wrapped.
  assign rd_first = (wraps_q != '0) ? ((wi_q == BUF_LAST) ? '0 : wi_q + 1'b1) : '0;
  assign rd_sum   = {1'b0, rd_first} + {1'b0, ofs_q[BUF_AW-1:0]};
  assign rd_pos   = (rd_sum >= (BUF_AW+1)'(BUF_DEPTH)) ?
                    BUF_AW'(rd_sum - (BUF_AW+1)'(BUF_DEPTH)) : rd_sum[BUF_AW-1:0];
  assign rd_miss  = rd_stop_q | (ofs_q >= OFS_END) | ~filled_q[rd_pos];

  always_comb begin
    dur_d     = dur_q;
    win_ok_d  = win_ok_q;
    prev_d    = prev_q;
    ended_d   = ended_q;
    armed_d   = armed_q;
    lvl_d     = lvl_q;
    wi_d      = wi_q;
    wraps_d   = wraps_q;
    count_d   = count_q;
    total_d   = total_q;
    filled_d  = filled_q;
    ofs_d     = ofs_q;
    rd_stop_d = rd_stop_q;
    rd_hit_d  = rd_hit_q;
    val_d     = val_q;
    valid_d   = valid_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    if (ctl_i.load) begin
      val_d   = '0;
      valid_d = 1'b0;
    end

    if (ctl_i.edge_calc) begin
      dur_d    = diff[31:1];
      win_ok_d = (count_q > {16'b0, count_min_q}) &&
                 ((count_q < {16'b0, count_max_q}) || (count_max_q == '0));
    end

    if (ctl_i.edge_commit && !ended_q) begin
      prev_d = item_q.timestamp;
      if ((prev_q != '0) && arm_nx) begin
        armed_d  = 1'b1;
        ram_we   = 1'b1;
        filled_d = filled_base;
        filled_d[wi_base] = 1'b1;
        lvl_d    = (lvl_base == LVL_NONE) ?
                   (item_q.edge_rising ? LVL_LOW : LVL_HIGH) : lvl_base;
        count_d  = count_base + 32'd1;
        total_d  = total_base + {17'b0, dur_sat};
        ended_d  = end_now;
        wi_d     = wi_base;
        wraps_d  = wraps_base;
        if (clr_now) begin
          ofs_d     = '0;
          rd_stop_d = 1'b0;
        end
        if (!end_now) begin
          wi_d = wi_next;
          if ((wi_base == BUF_LAST) && (wraps_base != WRAP_MAX)) begin
            wraps_d = wraps_base + 16'd1;
          end
        end
      end
    end

    if (ctl_i.rd_issue) begin
      if (rd_miss) begin
        rd_stop_d = 1'b1;
        rd_hit_d  = 1'b0;
      end else begin
        ram_re   = 1'b1;
        rd_hit_d = 1'b1;
        ofs_d    = ofs_q + 1'b1;
      end
    end

    if (ctl_i.rd_take) begin
      val_d   = rd_hit_q ? $signed(ram_rdata) : '0;
      valid_d = rd_hit_q;
    end

    if (ctl_i.restart) begin
      prev_d    = '0;
      ended_d   = 1'b0;
      armed_d   = 1'b0;
      lvl_d     = LVL_NONE;
      wi_d      = '0;
      wraps_d   = '0;
      count_d   = '0;
      total_d   = '0;
      filled_d  = '0;
      ofs_d     = '0;
      rd_stop_d = 1'b0;
    end

    if (ctl_i.stop) begin
      ended_d = 1'b1;
    end
  end

  assign result_o.capture_done   = ended_q;
  assign result_o.start_seen     = armed_q;
  assign result_o.pulse_count    = count_q;
  assign result_o.train_duration = total_q;
  assign result_o.overflow_total = wraps_q;
  assign result_o.first_level    = lvl_q;
  assign result_o.pulse_value    = val_q;
  assign result_o.pulse_valid    = valid_q;

endmodule

[rtl/rfptc_checker.sv]
// Port-level checker of the pulse train capture block, with its bind.
`include "rf_pulse_train_capture_defines.svh"

module rfptc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic                 result_valid_o,
  input rfptc_pkg::result_t   result_o
);

  `RFPTC_ASSERT_NOW(a_strobe_busy, result_valid_o, busy_o, "result strobe while idle")
  `RFPTC_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted word not busy")
  `RFPTC_ASSERT_NEXT(a_accept_no_strobe, start_i && !busy_o, !result_valid_o, "result too early")
  `RFPTC_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o && !busy_o,
                     "result strobe not single or block stays busy")
  `RFPTC_ASSERT_NOW(a_read_only_value, result_valid_o && !result_o.pulse_valid,
                    result_o.pulse_value == 16'sd0, "pulse value without valid pulse")

endmodule

bind rf_pulse_train_capture rfptc_checker u_rfptc_checker (.*);
